// ===== hdl/efpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package efpi_pkg;

    localparam int MAX_SAMPLES = 128;
    localparam int POS_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = POS_W + 1;
    localparam int ROW_W = POS_W - 1;
    localparam int ADDR_W = ROW_W + 1;

    localparam logic [31:0] SYNC_WORD = 32'h2A50D5AF;
    localparam logic [31:0] LEN_REPEAT = 32'd4;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic signed [16:0] SAMPLE_OFFSET = 17'sd30000;
    localparam logic signed [16:0] MIN_DEPTH = -17'sd64;
    localparam logic [7:0] POS_WINDOW = 8'd30;
    localparam logic [20:0] RECIP_TEN = 21'd1677722;
    localparam int RECIP_SHIFT = 24;
    localparam logic [4:0] SUM_LEN = 5'd20;
    localparam logic [22:0] FIRST_CHAN_WORD = 23'd7;

    typedef enum logic [1:0] {
        PH_SYNC,
        PH_LEN,
        PH_ID,
        PH_BLOCK
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PED,
        B_SUM,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [31:0] event_id;
        logic [31:0] device_ident;
        logic [61:0] time_ns;
        logic [14:0] global_channel;
        logic [POS_W-1:0] min_index;
        logic signed [20:0] ped_sum;
        logic bank;
    } job_t;

    typedef struct packed {
        logic even_en;
        logic [ADDR_W-1:0] even_addr;
        logic signed [16:0] even_data;
        logic odd_en;
        logic [ADDR_W-1:0] odd_addr;
        logic signed [16:0] odd_data;
    } mem_wr_t;

endpackage
`default_nettype wire

// ===== hdl/efpi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module efpi_front import efpi_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [6:0]  min_pos_lower,
    input  wire logic [31:0] s_word,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        q_full,
    output logic             push,
    output job_t             push_job,
    output mem_wr_t          mem_wr
);

    phase_t phase_reg, phase_next;
    logic [29:0] ewl_reg, ewl_next;
    logic [31:0] event_id_reg, event_id_next;
    logic [22:0] bi_reg, bi_next;
    logic [22:0] blen_reg, blen_next;
    logic [31:0] device_reg, device_next;
    logic [61:0] prod_reg, prod_next;
    logic [61:0] ts_reg, ts_next;
    logic [6:0] wpc_reg, wpc_next;
    logic [5:0] cw_reg, cw_next;
    logic [7:0] adc_reg, adc_next;
    logic [8:0] cb_reg, cb_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [16:0] minv_reg, minv_next;
    logic [POS_W-1:0] mini_reg, mini_next;
    logic signed [20:0] ped_reg, ped_next;
    logic bank_reg, bank_next;

    logic take;

    assign s_ready = !q_full;
    assign take = s_valid && s_ready;

    always_comb begin
        logic [6:0] wpc_use;
        logic [5:0] cw_cur;
        logic [7:0] lb_m1;
        logic fits;
        logic signed [16:0] v1, v2;
        logic [CNT_W-1:0] c1;
        logic [22:0] bi_inc;
        logic good;

        phase_next = phase_reg;
        ewl_next = ewl_reg;
        event_id_next = event_id_reg;
        bi_next = bi_reg;
        blen_next = blen_reg;
        device_next = device_reg;
        prod_next = prod_reg;
        ts_next = ts_reg;
        wpc_next = wpc_reg;
        cw_next = cw_reg;
        adc_next = adc_reg;
        cb_next = cb_reg;
        cnt_next = cnt_reg;
        minv_next = minv_reg;
        mini_next = mini_reg;
        ped_next = ped_reg;
        bank_next = bank_reg;
        push = 1'b0;
        mem_wr = '0;
        wpc_use = wpc_reg;
        cw_cur = cw_reg;
        lb_m1 = s_word[7:0] - 8'd1;
        fits = 1'b0;
        v1 = $signed({s_word[31], s_word[31:16]}) - SAMPLE_OFFSET;
        v2 = $signed({s_word[15], s_word[15:0]}) - SAMPLE_OFFSET;
        c1 = cnt_reg + CNT_W'(1);
        bi_inc = bi_reg + 23'd1;
        good = 1'b0;

        if (take) begin
            unique case (phase_reg)
                PH_SYNC: begin
                    if (s_word == SYNC_WORD) phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (s_word != LEN_REPEAT) begin
                        ewl_next = s_word[31:2];
                        phase_next = (s_word[31:2] == 30'd0) ? PH_SYNC : PH_ID;
                    end
                end
                PH_ID: begin
                    event_id_next = s_word;
                    bi_next = '0;
                    blen_next = '0;
                    adc_next = '0;
                    cw_next = '0;
                    ewl_next = ewl_reg - 30'd1;
                    phase_next = (ewl_reg == 30'd1) ? PH_SYNC : PH_BLOCK;
                end
                PH_BLOCK: begin
                    if (bi_reg == 23'd0) begin
                        device_next = s_word;
                    end else if (bi_reg == 23'd1) begin
                        blen_next = {1'b0, s_word[23:2]} + 23'd2;
                    end else if (bi_reg == 23'd3) begin
                        prod_next = s_word * NS_PER_SEC;
                    end else if (bi_reg == 23'd4) begin
                        ts_next = prod_reg + {32'd0, s_word[31:2]};
                    end else if (bi_reg >= FIRST_CHAN_WORD && blen_reg > FIRST_CHAN_WORD) begin
                        if (bi_reg == FIRST_CHAN_WORD) begin
                            wpc_use = (s_word[7:0] == 8'd0) ? 7'd1
                                    : {1'b0, lb_m1[7:2]} + 7'd1;
                            wpc_next = wpc_use;
                            cw_cur = '0;
                            cw_next = '0;
                        end
                        // a channel starts only if its whole record fits in the block
                        fits = ({1'b0, bi_reg} + {17'd0, wpc_use}) <= {1'b0, blen_reg};
                        if (cw_cur != 6'd0 || fits) begin
                            if (cw_cur == 6'd0) begin
                                cb_next = {1'b0, s_word[31:24]} + 9'd1;
                                cnt_next = CNT_W'(1);
                                ped_next = '0;
                                minv_next = $signed({8'd0, cb_next});
                                mini_next = '0;
                                mem_wr.even_en = 1'b1;
                                mem_wr.even_addr = {bank_reg, {ROW_W{1'b0}}};
                                mem_wr.even_data = $signed({8'd0, cb_next});
                            end else if (cw_cur >= 6'd3) begin
                                // count is odd here: upper half lands on an odd position
                                if (cnt_reg < CNT_W'(MAX_SAMPLES)) begin
                                    mem_wr.odd_en = 1'b1;
                                    mem_wr.odd_addr = {bank_reg, cnt_reg[POS_W-1:1]};
                                    mem_wr.odd_data = v1;
                                    if (cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(10))
                                        ped_next = ped_next + 21'(v1);
                                    if (v1 < minv_next) begin
                                        minv_next = v1;
                                        mini_next = cnt_reg[POS_W-1:0];
                                    end
                                    cnt_next = c1;
                                end
                                if (c1 < CNT_W'(MAX_SAMPLES)) begin
                                    mem_wr.even_en = 1'b1;
                                    mem_wr.even_addr = {bank_reg, c1[POS_W-1:1]};
                                    mem_wr.even_data = v2;
                                    if (c1 >= CNT_W'(1) && c1 <= CNT_W'(10))
                                        ped_next = ped_next + 21'(v2);
                                    if (v2 < minv_next) begin
                                        minv_next = v2;
                                        mini_next = c1[POS_W-1:0];
                                    end
                                    cnt_next = c1 + CNT_W'(1);
                                end
                            end
                            if ({1'b0, cw_cur} + 7'd1 >= wpc_use) begin
                                cw_next = '0;
                                good = (minv_next < MIN_DEPTH)
                                    && ({1'b0, mini_next} > {1'b0, min_pos_lower})
                                    && ({1'b0, mini_next} < {1'b0, min_pos_lower} + POS_WINDOW)
                                    && (mini_next >= POS_W'(4))
                                    && ({1'b0, mini_next} + (CNT_W)'(16) <= cnt_next);
                                if (good) begin
                                    push = 1'b1;
                                    bank_next = !bank_reg;
                                end
                            end else begin
                                cw_next = cw_cur + 6'd1;
                            end
                        end
                    end
                    if (bi_inc >= 23'd2 && bi_inc >= blen_next) begin
                        bi_next = '0;
                        adc_next = adc_reg + 8'd1;
                    end else begin
                        bi_next = bi_inc;
                    end
                    ewl_next = ewl_reg - 30'd1;
                    if (ewl_reg == 30'd1) phase_next = PH_SYNC;
                end
            endcase
        end
    end

    always_comb begin
        push_job.event_id = event_id_reg;
        push_job.device_ident = device_reg;
        push_job.time_ns = ts_reg;
        push_job.global_channel = {6'd0, cb_next} + {1'b0, adc_reg, 6'd0};
        push_job.min_index = mini_next;
        push_job.ped_sum = ped_next;
        push_job.bank = bank_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC;
            ewl_reg <= '0;
            event_id_reg <= '0;
            bi_reg <= '0;
            blen_reg <= '0;
            device_reg <= '0;
            ts_reg <= '0;
            wpc_reg <= 7'd1;
            cw_reg <= '0;
            adc_reg <= '0;
            cb_reg <= '0;
            cnt_reg <= '0;
            minv_reg <= '0;
            mini_reg <= '0;
            ped_reg <= '0;
            bank_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            ewl_reg <= ewl_next;
            event_id_reg <= event_id_next;
            bi_reg <= bi_next;
            blen_reg <= blen_next;
            device_reg <= device_next;
            ts_reg <= ts_next;
            wpc_reg <= wpc_next;
            cw_reg <= cw_next;
            adc_reg <= adc_next;
            cb_reg <= cb_next;
            cnt_reg <= cnt_next;
            minv_reg <= minv_next;
            mini_reg <= mini_next;
            ped_reg <= ped_next;
            bank_reg <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

// ===== hdl/efpi_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module efpi_queue import efpi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output logic      q_full,
    output logic      q_valid,
    output job_t      head
);

    job_t slot_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign q_full = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ===== hdl/efpi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module efpi_back import efpi_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  mem_wr_t            mem_wr,
    input  wire logic          q_valid,
    input  job_t               head,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [167:0]       m_data
);

    logic signed [16:0] even_mem [2**ADDR_W];
    logic signed [16:0] odd_mem [2**ADDR_W];

    back_state_t state_reg, state_next;
    logic signed [16:0] ped_reg;
    logic [4:0] n_reg;
    logic [POS_W-1:0] pos_reg;
    logic dv_reg;
    logic sel_reg;
    logic signed [16:0] rd_even_reg, rd_odd_reg;
    logic signed [22:0] acc_reg;
    logic m_valid_reg;
    logic [167:0] m_data_reg;

    logic issue, out_load, out_free;
    logic [19:0] ped_abs;
    logic [40:0] ped_prod;
    logic [16:0] ped_q;
    logic signed [22:0] ped_ext, charge_full;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (q_valid) state_next = B_PED;
            B_PED:  state_next = B_SUM;
            B_SUM:  if (n_reg == SUM_LEN && dv_reg) state_next = B_DONE;
            B_DONE: if (out_free) state_next = B_IDLE;
        endcase
    end

    always_comb begin
        issue = (state_reg == B_SUM) && (n_reg < SUM_LEN);
        out_load = (state_reg == B_DONE) && out_free;
        pop = out_load;
    end

    // truncating divide by ten through a reciprocal, on the magnitude
    always_comb begin
        ped_abs = head.ped_sum[20] ? 20'(-head.ped_sum) : head.ped_sum[19:0];
        ped_prod = ped_abs * RECIP_TEN;
        ped_q = ped_prod[RECIP_SHIFT+16:RECIP_SHIFT];
        ped_ext = {{6{ped_reg[16]}}, ped_reg};
        charge_full = (ped_ext <<< 4) + (ped_ext <<< 2) - acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr.even_en) even_mem[mem_wr.even_addr] <= mem_wr.even_data;
        if (mem_wr.odd_en) odd_mem[mem_wr.odd_addr] <= mem_wr.odd_data;
        rd_even_reg <= even_mem[{head.bank, pos_reg[POS_W-1:1]}];
        rd_odd_reg <= odd_mem[{head.bank, pos_reg[POS_W-1:1]}];
        sel_reg <= pos_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_PED) begin
            ped_reg <= head.ped_sum[20] ? -$signed(ped_q) : $signed(ped_q);
            pos_reg <= head.min_index - POS_W'(4);
            acc_reg <= '0;
        end else begin
            if (issue) pos_reg <= pos_reg + POS_W'(1);
            if (dv_reg) acc_reg <= acc_reg + 23'(sel_reg ? rd_odd_reg : rd_even_reg);
        end
        if (out_load)
            m_data_reg <= {5'd0, charge_full[21:0], head.global_channel, head.time_ns,
                           head.device_ident, head.event_id};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            n_reg <= '0;
            dv_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            dv_reg <= issue;
            if (state_reg == B_PED) n_reg <= '0;
            else if (issue) n_reg <= n_reg + 5'd1;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != B_IDLE |-> q_valid)
        else $error("back end busy without a queued job");
    a_last_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SUM && n_reg == SUM_LEN) |-> dv_reg)
        else $error("window sum finished without its last sample");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

// ===== hdl/event_frame_pulse_integrator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Parses a digitizer word stream (one 32-bit word per transfer) and emits one
// charge result per channel whose first minimum is deep enough and lies in the
// configured position window. The front end takes one word per cycle while
// the job queue is not full; the back end handles each emitted channel with a
// pedestal divide, 20 sample reads from the waveform memory and an output load.
// A two-entry job queue and two waveform banks let the front end store the next
// channels meanwhile; s_tready drops only while two results are still queued.
module event_frame_pulse_integrator_top import efpi_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [6:0]   cfg_wr_data,    // min_position_lower
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,        // stream_word
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // event_id, device_ident, time_ns, global_channel, charge, zero pad
    output logic [167:0]      m_tdata
);

    logic [6:0] lower_reg;
    logic q_full, q_valid, push, pop;
    job_t push_job, head;
    mem_wr_t mem_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) lower_reg <= 7'd25;
        else if (cfg_wr_en) lower_reg <= cfg_wr_data;
    end

    efpi_front u_front (
        .aclk(aclk), .aresetn(aresetn), .min_pos_lower(lower_reg),
        .s_word(s_tdata), .s_valid(s_tvalid), .s_ready(s_tready),
        .q_full(q_full), .push(push), .push_job(push_job), .mem_wr(mem_wr)
    );

    efpi_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_job(push_job),
        .pop(pop), .q_full(q_full), .q_valid(q_valid), .head(head)
    );

    efpi_back u_back (
        .aclk(aclk), .aresetn(aresetn), .mem_wr(mem_wr), .q_valid(q_valid),
        .head(head), .pop(pop), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_data(m_tdata)
    );

endmodule
`default_nettype wire
